// ===== rtl/wltp_pkg.sv =====
`default_nettype none

package wltp_pkg;

    // Reset value of the tower distance register (100 mm in Q16.16)
    localparam logic [30:0] TOWER_DIST_RESET = 31'd6553600;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Quotient bits produced by the divider, one per stage
    localparam int DIV_STEPS   = 34;
    // Multiply, sum, divide steps, round, output
    localparam int BACK_STAGES = DIV_STEPS + 4;

    // Lane order on the output word
    localparam int LANE_PLUS_Y  = 0;
    localparam int LANE_PLUS_Z  = 1;
    localparam int LANE_MINUS_Y = 2;
    localparam int LANE_MINUS_Z = 3;
    localparam int LANES        = 4;

    // One classified point pair, as queued for the back end
    typedef struct packed {
        logic               last;
        logic               deg;
        logic signed [31:0] y1;
        logic signed [31:0] z1;
        logic [33:0]        den_mag;
        logic [32:0]        span_plus_mag;
        logic [32:0]        span_minus_mag;
        logic [31:0]        dy_mag;
        logic [31:0]        dz_mag;
        logic [3:0]         neg;
    } t_entry;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/wltp_front.sv =====
`default_nettype none

module wltp_front
    import wltp_pkg::*;
(
    input  wire logic [30:0]        i_dist,
    input  wire logic signed [31:0] i_near_x,
    input  wire logic signed [31:0] i_near_y,
    input  wire logic signed [31:0] i_near_z,
    input  wire logic signed [31:0] i_far_x,
    input  wire logic signed [31:0] i_far_y,
    input  wire logic signed [31:0] i_far_z,
    input  wire logic               i_last,
    output t_entry                  o_entry
);

    logic signed [34:0] two_x1;
    logic signed [34:0] dist_ext;
    logic signed [34:0] span_plus;
    logic signed [34:0] span_minus;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [32:0]        dx_abs;
    logic [32:0]        dy_abs;
    logic [32:0]        dz_abs;
    logic [34:0]        sp_abs;
    logic [34:0]        sm_abs;
    logic               s_sp;
    logic               s_sm;

    // Form spans to both tower planes, doubled so the half distance stays exact
    always_comb begin
        two_x1     = {{2{i_near_x[31]}}, i_near_x, 1'b0};
        dist_ext   = {4'b0, i_dist};
        span_plus  = dist_ext - two_x1;
        span_minus = -dist_ext - two_x1;
        dx = {i_far_x[31], i_far_x} - {i_near_x[31], i_near_x};
        dy = {i_far_y[31], i_far_y} - {i_near_y[31], i_near_y};
        dz = {i_far_z[31], i_far_z} - {i_near_z[31], i_near_z};
        s_sp   = span_plus[34];
        s_sm   = span_minus[34];
        sp_abs = s_sp ? 35'(-span_plus) : 35'(span_plus);
        sm_abs = s_sm ? 35'(-span_minus) : 35'(span_minus);
        dx_abs = dx[32] ? 33'(-dx) : 33'(dx);
        dy_abs = dy[32] ? 33'(-dy) : 33'(dy);
        dz_abs = dz[32] ? 33'(-dz) : 33'(dz);
    end

    // Classify into magnitudes and result signs
    always_comb begin
        o_entry.last           = i_last;
        o_entry.deg            = (dx == '0);
        o_entry.y1             = i_near_y;
        o_entry.z1             = i_near_z;
        o_entry.den_mag        = {dx_abs, 1'b0};
        o_entry.span_plus_mag  = sp_abs[32:0];
        o_entry.span_minus_mag = sm_abs[32:0];
        o_entry.dy_mag         = dy_abs[31:0];
        o_entry.dz_mag         = dz_abs[31:0];
        o_entry.neg[LANE_PLUS_Y]  = s_sp ^ dy[32] ^ dx[32];
        o_entry.neg[LANE_PLUS_Z]  = s_sp ^ dz[32] ^ dx[32];
        o_entry.neg[LANE_MINUS_Y] = s_sm ^ dy[32] ^ dx[32];
        o_entry.neg[LANE_MINUS_Z] = s_sm ^ dz[32] ^ dx[32];
    end

endmodule

`default_nettype wire

// ===== rtl/wltp_queue.sv =====
`default_nettype none

module wltp_queue
    import wltp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_entry  i_entry,
    input  wire logic    i_pop,
    output t_entry       o_entry,
    output t_queue_status o_status
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW:0]   n_cnt;

    assign o_status.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_entry        = r_mem[r_rp];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/wltp_lane.sv =====
`default_nettype none

module wltp_lane
    import wltp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [32:0]        i_span_mag,
    input  wire logic [31:0]        i_dc_mag,
    input  wire logic               i_neg,
    input  wire logic signed [31:0] i_c1,
    input  wire logic [33:0]        i_den,
    output logic signed [31:0]      o_value
);

    // Multiply stage
    logic [48:0]        r_plo;
    logic [47:0]        r_phi;
    logic               r_m_neg;
    logic signed [31:0] r_m_c1;
    logic [33:0]        r_m_den;

    // Divider stages; index 0 is the sum stage
    logic [34:0]          r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_num [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic signed [31:0]   r_c1  [DIV_STEPS+1];
    logic [33:0]          r_den [DIV_STEPS+1];

    // Round stage
    logic [34:0]        r_qr;
    logic               r_r_neg;
    logic signed [31:0] r_r_c1;

    logic [64:0]        num;
    logic [30:0]        rem0;
    logic [34:0]        n_qr;
    logic signed [36:0] v;
    logic signed [36:0] sum;

    // Split the product into two narrow multiplies
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo   <= i_span_mag[16:0] * i_dc_mag;
            r_phi   <= i_span_mag[32:17] * i_dc_mag;
            r_m_neg <= i_neg;
            r_m_c1  <= i_c1;
            r_m_den <= i_den;
        end
    end

    // Join partial products, check for a quotient past the divider range
    always_comb begin
        num  = {r_phi, 17'b0} + {16'b0, r_plo};
        rem0 = num[64:34];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {4'b0, rem0};
            r_quo[0] <= '0;
            r_num[0] <= num[33:0];
            r_ovf[0] <= ({3'b0, rem0} >= r_m_den);
            r_neg[0] <= r_m_neg;
            r_c1[0]  <= r_m_c1;
            r_den[0] <= r_m_den;
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [34:0] trial;
        logic        take;

        always_comb begin
            trial = {r_rem[k-1][33:0], r_num[k-1][DIV_STEPS-k]};
            take  = (trial >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? (trial - {1'b0, r_den[k-1]}) : trial;
                r_quo[k] <= r_quo[k-1] | (take ? (DIV_STEPS'(1) << (DIV_STEPS-k)) : '0);
                r_num[k] <= r_num[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
                r_c1[k]  <= r_c1[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    // Round half away from zero; a large quotient clamps to a saturating value
    always_comb begin
        if (r_ovf[DIV_STEPS]) begin
            n_qr = 35'(1) << DIV_STEPS;
        end else begin
            n_qr = {1'b0, r_quo[DIV_STEPS]}
                 + 35'({r_rem[DIV_STEPS][33:0], 1'b0} >= {1'b0, r_den[DIV_STEPS]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr    <= n_qr;
            r_r_neg <= r_neg[DIV_STEPS];
            r_r_c1  <= r_c1[DIV_STEPS];
        end
    end

    // Apply sign, add base coordinate, saturate
    always_comb begin
        v   = r_r_neg ? -$signed({2'b0, r_qr}) : $signed({2'b0, r_qr});
        sum = {{5{r_r_c1[31]}}, r_r_c1} + v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sum > 37'sd2147483647) begin
                o_value <= 32'sh7FFFFFFF;
            end else if (sum < -37'sd2147483648) begin
                o_value <= 32'sh80000000;
            end else begin
                o_value <= sum[31:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wltp_back.sv =====
`default_nettype none

module wltp_back
    import wltp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_entry  i_entry,
    input  wire t_queue_status i_status,
    output logic         o_pop,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output logic [127:0] o_tdata,
    output logic         o_deg,
    output logic         o_last
);

    logic               r_vld  [BACK_STAGES];
    logic               r_deg  [BACK_STAGES];
    logic               r_last [BACK_STAGES];
    logic               en;
    logic signed [31:0] lane_val [LANES];

    // Whole pipeline moves when the output word is free or taken
    assign en       = !r_vld[BACK_STAGES-1] || i_tready;
    assign o_pop    = en && !i_status.empty;
    assign o_tvalid = r_vld[BACK_STAGES-1];
    assign o_deg    = r_deg[BACK_STAGES-1];
    assign o_last   = r_last[BACK_STAGES-1];

    // Carry valid and flags alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < BACK_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= !i_status.empty;
            for (int s = 1; s < BACK_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg[0]  <= i_entry.deg;
            r_last[0] <= i_entry.last;
            for (int s = 1; s < BACK_STAGES; s++) begin
                r_deg[s]  <= r_deg[s-1];
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // One lane per output coordinate
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        wltp_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_span_mag ((l == LANE_PLUS_Y || l == LANE_PLUS_Z) ?
                         i_entry.span_plus_mag : i_entry.span_minus_mag),
            .i_dc_mag   ((l == LANE_PLUS_Y || l == LANE_MINUS_Y) ?
                         i_entry.dy_mag : i_entry.dz_mag),
            .i_neg      (i_entry.neg[l]),
            .i_c1       ((l == LANE_PLUS_Y || l == LANE_MINUS_Y) ?
                         i_entry.y1 : i_entry.z1),
            .i_den      (i_entry.den_mag),
            .o_value    (lane_val[l])
        );
        // Degenerate pairs report zero coordinates
        assign o_tdata[32*l +: 32] = o_deg ? 32'b0 : lane_val[l];
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_last)))
        else $error("result changed while stalled");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_deg) |-> (o_tdata == '0))
        else $error("degenerate result not zero");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0])
        else $error("popped word lost");

endmodule

`default_nettype wire

// ===== rtl/wire_line_tower_projection.sv =====
// Path of an accepted input word to its result word: queue write, then multiply,
//   partial-product sum, 34 divider stages, round and output in the back end.
// Throughput: one point pair per cycle while the output is not stalled; the back end is a
//   38-stage pipeline with a bit-per-stage restoring divider in four lanes, behind a 4-word queue.
// Reset (synchronous, active low): queue and pipeline empty, tower distance 100 mm.
`default_nettype none

module wire_line_tower_projection
    import wltp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [30:0]  i_cfg_wr_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // near_face_x, near_face_y, near_face_z, far_face_x, far_face_y, far_face_z
    input  wire logic [191:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // plus_tower_y, plus_tower_z, minus_tower_y, minus_tower_z
    output logic [127:0]      m_axis_tdata,
    // degenerate
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    logic [30:0]   r_tower_distance;
    t_entry        front_entry;
    t_entry        queue_entry;
    t_queue_status q_status;
    logic          push;
    logic          pop;

    // Hold the tower distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tower_distance <= TOWER_DIST_RESET;
        end else if (i_cfg_wr_en) begin
            r_tower_distance <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    wltp_front u_front (
        .i_dist   (r_tower_distance),
        .i_near_x (s_axis_tdata[31:0]),
        .i_near_y (s_axis_tdata[63:32]),
        .i_near_z (s_axis_tdata[95:64]),
        .i_far_x  (s_axis_tdata[127:96]),
        .i_far_y  (s_axis_tdata[159:128]),
        .i_far_z  (s_axis_tdata[191:160]),
        .i_last   (s_axis_tlast),
        .o_entry  (front_entry)
    );

    wltp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    wltp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (queue_entry),
        .i_status (q_status),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_deg    (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== test/wltp_checker.sv =====
`timescale 1ns / 100ps

module wltp_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [30:0]  i_cfg_wr_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,
    input  wire logic         m_tuser,
    input  wire logic         m_tlast,
    output int                o_fail_count,
    output int                o_pending
);
    import wltp_pkg::*;

    typedef struct packed {
        logic        last;
        logic        deg;
        logic [31:0] minus_z;
        logic [31:0] minus_y;
        logic [31:0] plus_z;
        logic [31:0] plus_y;
    } t_crossing;

    t_crossing   crossing_q[$];
    logic [30:0] tower_dist;

    // Round-to-nearest (ties away) of a*b/d, magnitude clamped to 2^40
    function automatic logic signed [63:0] ratio_round(input logic signed [63:0] a,
            input logic signed [63:0] b, input logic signed [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [63:0]  am;
        logic [63:0]  bm;
        logic [63:0]  dm;
        logic         neg;
        logic [63:0]  q;
        am   = a < 0 ? -a : a;
        bm   = b < 0 ? -b : b;
        dm   = d < 0 ? -d : d;
        neg  = ((a < 0) != (b < 0)) != (d < 0);
        prod = am * bm;
        quo  = prod / dm;
        rem  = prod % dm;
        if (rem >= dm - rem) quo = quo + 1;
        q = (quo > (128'd1 << 40)) ? (64'd1 << 40) : quo[63:0];
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_crossing project_pair(input logic [191:0] d, input logic lst);
        t_crossing r;
        logic signed [63:0] x1, y1, z1, dx, dy, dz, sp, sm, den;
        x1 = $signed(d[31:0]);
        y1 = $signed(d[63:32]);
        z1 = $signed(d[95:64]);
        dx = $signed(d[127:96]) - x1;
        dy = $signed(d[159:128]) - y1;
        dz = $signed(d[191:160]) - z1;
        r = '0;
        r.last = lst;
        if (dx == 0) begin
            r.deg = 1'b1;
            return r;
        end
        sp  = $signed({33'd0, tower_dist}) - 2 * x1;
        sm  = -$signed({33'd0, tower_dist}) - 2 * x1;
        den = 2 * dx;
        r.plus_y  = clamp32(y1 + ratio_round(sp, dy, den));
        r.plus_z  = clamp32(z1 + ratio_round(sp, dz, den));
        r.minus_y = clamp32(y1 + ratio_round(sm, dy, den));
        r.minus_z = clamp32(z1 + ratio_round(sm, dz, den));
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    // Predict on accepted input words, compare accepted output words
    always @(posedge i_clk) begin
        t_crossing got;
        t_crossing want;
        if (!i_rst_n) begin
            tower_dist   <= TOWER_DIST_RESET;
            o_fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) crossing_q.push_back(project_pair(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tuser, m_tdata};
                if (crossing_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h act %h", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_wr_en) tower_dist <= i_cfg_wr_data;
        end
    end
endmodule

// ===== test/wire_line_tower_projection_tb.sv =====
`timescale 1ns / 100ps

module wire_line_tower_projection_tb;
    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [30:0]  i_cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           hold_off;

    wire_line_tower_projection DUT (.*);

    wltp_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data,
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tlast(s_axis_tlast),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser), .m_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return 32'h7FFFFFFF - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h01400000)) - 32'sh00A00000;
        endcase
    endfunction

    // Receiver: random stalls, with long hold-off on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        hold_off = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready = 1'b0;
                hold_off = hold_off - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                n = gap_len();
                m_axis_tready = 1'b0;
                repeat (n) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic [191:0] d, input logic lst);
        int n;
        n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        repeat (n) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tlast  = lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_dist(input logic [30:0] v);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic send_pair(input logic [31:0] x1, y1, z1, x2, y2, z2, input logic lst);
        send_word({z2, y2, x2, z1, y1, x1}, lst);
    endtask

    initial begin
        logic [31:0] x1;
        logic [30:0] dists[5];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset distance, degenerate, extremes, overflow, rounding ties
        send_pair(32'h00010000, 32'h00020000, 32'h00030000,
                  32'hFFFF0000, 32'h00050000, 32'hFFFD0000, 1'b0);
        send_pair(32'h00050000, 32'h11, 32'h22, 32'h00050000, 32'h33, 32'h44, 1'b1);
        send_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        send_pair(32'h0, 32'h7FFFFFF0, 32'h80000010, 32'h1, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_pair(32'h1, 32'h0, 32'h0, 32'h3, 32'h1, 32'hFFFFFFFF, 1'b0);
        send_pair(32'h7FFFFFFF, 32'h5, 32'h5, 32'h7FFFFFFF, 32'h5, 32'h5, 1'b0);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'h0, 32'h0, 32'h0, 1'b1);
        drain();

        dists[0] = 31'd0;
        dists[1] = 31'h7FFFFFFF;
        dists[2] = 31'd1;
        dists[3] = 31'd13107200;
        dists[4] = 31'd6553600;
        foreach (dists[p]) begin
            write_dist(dists[p]);
            send_pair(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h10000, 1'b0);
            send_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
            // Fill the block while the receiver holds off
            if (p == 1) begin
                hold_off = 300;
                repeat (20) send_pair(coord(), coord(), coord(), coord(), coord(), coord(),
                                      1'b0);
            end
            for (int i = 0; i < 340; i++) begin
                x1 = coord();
                send_pair(x1, coord(), coord(),
                          ($urandom_range(0, 19) == 0) ? x1 : coord(),
                          coord(), coord(), 1'($urandom_range(0, 1)));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/wltp_pkg.sv
rtl/wltp_front.sv
rtl/wltp_queue.sv
rtl/wltp_lane.sv
rtl/wltp_back.sv
rtl/wire_line_tower_projection.sv
test/wltp_checker.sv
test/wire_line_tower_projection_tb.sv
